### hw/rtl/motbl_pkg.sv
// Package for the masked opcode match table: sizes, command and register codes,
// beat structs for the channels and the byte assembly / trailing zero helpers.
// No dependencies.
`timescale 1ns / 1ps

package motbl_pkg;

    // Table geometry
    localparam int TBL_ENTRIES = 64;
    localparam int IDX_W       = 6;
    localparam int MAX_ARGS    = 4;
    localparam int SLOT_W      = 2;
    localparam int WORD_W      = 32;
    localparam int WIN_BYTES   = 4;
    localparam int LEN_W       = 3;
    localparam int CTZ_W       = 5;

    // Priority pick is split into groups of eight entries
    localparam int GRP_SIZE  = 8;
    localparam int LOC_W     = 3;
    localparam int GRP_COUNT = TBL_ENTRIES / GRP_SIZE;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int EIU_W      = 7;

    typedef enum logic [1:0] {
        CMD_WR_ENTRY = 2'd0,
        CMD_WR_AMASK = 2'd1,
        CMD_DECODE   = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES_IN_USE = 2'd0,
        CFG_BYTE_ORDER     = 2'd1,
        CFG_MISS_ADVANCE   = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [SLOT_W-1:0] arg_slot;
        logic [WORD_W-1:0] mask_word;
        logic [WORD_W-1:0] value_word;
        logic [LEN_W-1:0]  entry_size;
        logic [LEN_W-1:0]  arg_count;
        logic [WORD_W-1:0] window;
        logic [LEN_W-1:0]  bytes_valid;
    } t_in_beat;

    typedef struct packed {
        logic              matched;
        logic [IDX_W-1:0]  matched_entry;
        logic [WORD_W-1:0] instr_word;
        logic [LEN_W-1:0]  advance;
        logic [LEN_W-1:0]  found_arg_count;
        logic [WORD_W-1:0] arg_0;
        logic [WORD_W-1:0] arg_1;
        logic [WORD_W-1:0] arg_2;
        logic [WORD_W-1:0] arg_3;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  wr_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_beat;

    // Assemble the first nbytes of a window; little_end puts byte 0 lowest
    function automatic logic [WORD_W-1:0] assemble(
        input logic [WORD_W-1:0] win,
        input logic [LEN_W-1:0]  nbytes,
        input logic              little_end
    );
        logic [WORD_W-1:0] word;
        word = '0;
        for (int i = 0; i < WIN_BYTES; i++) begin
            if (LEN_W'(i) < nbytes) begin
                if (little_end) begin
                    word[8*i +: 8] = win[8*i +: 8];
                end else begin
                    word = {word[WORD_W-9:0], win[8*i +: 8]};
                end
            end
        end
        return word;
    endfunction

    // Trailing zero count, binary search; a zero word gives 31
    function automatic logic [CTZ_W-1:0] ctz32(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] x;
        logic [CTZ_W-1:0]  n;
        x = v;
        n = '0;
        if (x[15:0] == 16'h0) begin
            n[4] = 1'b1;
            x    = x >> 16;
        end
        if (x[7:0] == 8'h0) begin
            n[3] = 1'b1;
            x    = x >> 8;
        end
        if (x[3:0] == 4'h0) begin
            n[2] = 1'b1;
            x    = x >> 4;
        end
        if (x[1:0] == 2'h0) begin
            n[1] = 1'b1;
            x    = x >> 2;
        end
        if (x[0] == 1'b0) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

### hw/rtl/motbl_if.sv
// Channel interfaces for the masked opcode match table: command beats in,
// decode result beats out, and the configuration write channel. Uses motbl_pkg.
`timescale 1ns / 1ps

interface motbl_in_if import motbl_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface motbl_out_if import motbl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface motbl_cfg_if import motbl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/masked_opcode_match_table.sv
// First-match opcode decoder: pattern table, compare, priority pick, argument extraction.
// Depends on motbl_pkg and the channel interfaces in motbl_if.sv.
`timescale 1ns / 1ps

// Masked opcode match table. Each input beat is a table write (entry pattern or
// one argument mask) or a decode of a 4-byte code window; only decodes give a
// result beat. The block is a seven-stage pipeline that takes one beat every
// cycle when the output is not stalled. Its stages, in order, are the
// window assembly, parallel masked compare of the entries in use (up to 64),
// a two-level priority pick (eight groups of eight), a read of the entry's
// argument-mask row from memory, the masked word with trailing zero counts,
// and the final shift into the output register. Writes take effect in order
// with decodes, so a decode sees every write accepted before it. Entries must
// be written before a decode searches them. The user must write configuration
// only while the block holds no beats; the block itself does not enforce this.
module masked_opcode_match_table import motbl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    motbl_cfg_if.sink   i_cfg,
    motbl_in_if.sink    i_in,
    motbl_out_if.source o_out
);

    typedef struct packed {
        logic [LEN_W-1:0]                   size;
        logic [LEN_W-1:0]                   count;
        logic [MAX_ARGS-1:0][WORD_W-1:0]    amask;
    } t_row;

    typedef logic [WIN_BYTES-1:0][WORD_W-1:0] t_words;

    // Configuration registers
    logic [EIU_W-1:0] r_entries_in_use;
    logic             r_byte_order;
    logic [LEN_W-1:0] r_miss_advance;

    // Pattern table in flops, compared in parallel
    logic [WORD_W-1:0] r_pmask [TBL_ENTRIES];
    logic [WORD_W-1:0] r_pval  [TBL_ENTRIES];
    logic [LEN_W-1:0]  r_psize [TBL_ENTRIES];

    // Row memory: size, count and argument masks per entry
    t_row r_mem [TBL_ENTRIES];

    // Stage valids and enables
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid, r_out_valid;
    logic en1, en2, en3, en4, en5, en6, en7;

    // Stage 1: accepted beat and assembled words
    logic [1:0]        r1_cmd;
    logic [IDX_W-1:0]  r1_idx;
    logic [SLOT_W-1:0] r1_slot;
    logic [WORD_W-1:0] r1_mword, r1_vword;
    logic [LEN_W-1:0]  r1_size, r1_count, r1_vb, r1_madv;
    t_words            r1_words;
    logic [WORD_W-1:0] r1_missw;

    // Stage 2: hit vector
    logic [1:0]             r2_cmd;
    logic [TBL_ENTRIES-1:0] r2_hit;
    logic [IDX_W-1:0]       r2_idx;
    logic [SLOT_W-1:0]      r2_slot;
    logic [WORD_W-1:0]      r2_mword;
    logic [LEN_W-1:0]       r2_size, r2_count, r2_madv;
    t_words                 r2_words;
    logic [WORD_W-1:0]      r2_missw;

    // Stage 3: per-group pick
    logic [1:0]                        r3_cmd;
    logic [GRP_COUNT-1:0]              r3_gany;
    logic [GRP_COUNT-1:0][LOC_W-1:0]   r3_gloc;
    logic [IDX_W-1:0]                  r3_idx;
    logic [SLOT_W-1:0]                 r3_slot;
    logic [WORD_W-1:0]                 r3_mword;
    logic [LEN_W-1:0]                  r3_size, r3_count, r3_madv;
    t_words                            r3_words;
    logic [WORD_W-1:0]                 r3_missw;

    // Stage 4: final pick
    logic [1:0]        r4_cmd;
    logic              r4_found;
    logic [IDX_W-1:0]  r4_hidx;
    logic [IDX_W-1:0]  r4_widx;
    logic [SLOT_W-1:0] r4_slot;
    logic [WORD_W-1:0] r4_mword;
    logic [LEN_W-1:0]  r4_size, r4_count, r4_madv;
    t_words            r4_words;
    logic [WORD_W-1:0] r4_missw;

    // Stage 5: row read
    t_row              r5_row;
    logic              r5_found;
    logic [IDX_W-1:0]  r5_idx;
    logic [LEN_W-1:0]  r5_madv;
    t_words            r5_words;
    logic [WORD_W-1:0] r5_missw;

    // Stage 6: masked words and shift amounts
    logic                            r6_found;
    logic [IDX_W-1:0]                r6_idx;
    logic [WORD_W-1:0]               r6_word;
    logic [LEN_W-1:0]                r6_adv, r6_cnt;
    logic [MAX_ARGS-1:0][WORD_W-1:0] r6_masked;
    logic [MAX_ARGS-1:0][CTZ_W-1:0]  r6_ctz;

    t_out_beat r_out;

    // Next values
    t_in_beat                          in_beat;
    logic [LEN_W-1:0]                  n_vb, n_madv;
    logic [WORD_W-1:0]                 n_win;
    t_words                            n_words;
    logic [TBL_ENTRIES-1:0]            n_hit;
    logic [GRP_COUNT-1:0]              n_gany;
    logic [GRP_COUNT-1:0][LOC_W-1:0]   n_gloc;
    logic                              n_found;
    logic [IDX_W-1:0]                  n_hidx;
    logic [LEN_W-1:0]                  n_adv, n_cnt;
    logic [WORD_W-1:0]                 n_word;
    logic [MAX_ARGS-1:0][WORD_W-1:0]   n_masked;
    logic [MAX_ARGS-1:0][CTZ_W-1:0]    n_ctz;
    logic                              r1_is_wr, r4_is_dec;

    assign in_beat = i_in.data;

    // Backpressure chain: a stage loads when empty or when it drains
    assign en7 = !r_out_valid || o_out.ready;
    assign en6 = !r6_valid || en7;
    assign en5 = !r5_valid || en6;
    assign en4 = !r4_valid || en5;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;

    assign i_in.ready  = en1;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign r1_is_wr  = r1_valid && (r1_cmd == CMD_WR_ENTRY);
    assign r4_is_dec = r4_valid && (r4_cmd == CMD_DECODE);

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid         <= 1'b0;
            r2_valid         <= 1'b0;
            r3_valid         <= 1'b0;
            r4_valid         <= 1'b0;
            r5_valid         <= 1'b0;
            r6_valid         <= 1'b0;
            r_out_valid      <= 1'b0;
            r_entries_in_use <= '0;
            r_byte_order     <= 1'b0;
            r_miss_advance   <= LEN_W'(1);
        end else begin
            if (en1) r1_valid <= i_in.valid && (in_beat.cmd != CMD_NOP);
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
            if (en5) r5_valid <= r4_is_dec;
            if (en6) r6_valid <= r5_valid;
            if (en7) r_out_valid <= r6_valid;
            if (i_cfg.valid) begin
                case (i_cfg.data.wr_index)
                    CFG_ENTRIES_IN_USE: r_entries_in_use <= i_cfg.data.wr_data;
                    CFG_BYTE_ORDER:     r_byte_order     <= i_cfg.data.wr_data[0];
                    CFG_MISS_ADVANCE:   r_miss_advance   <= i_cfg.data.wr_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Stage 1 logic: clamp valid bytes, zero bytes past the program, assemble, clamp miss advance
    always_comb begin
        n_vb = (in_beat.bytes_valid > LEN_W'(WIN_BYTES)) ? LEN_W'(WIN_BYTES)
                                                         : in_beat.bytes_valid;
        for (int b = 0; b < WIN_BYTES; b++) begin
            n_win[8*b +: 8] = (LEN_W'(b) < n_vb) ? in_beat.window[8*b +: 8] : 8'h00;
        end
        for (int s = 0; s < WIN_BYTES; s++) begin
            n_words[s] = assemble(n_win, LEN_W'(s + 1), r_byte_order);
        end
        if (r_miss_advance == '0) begin
            n_madv = LEN_W'(1);
        end else if (r_miss_advance > LEN_W'(WIN_BYTES)) begin
            n_madv = LEN_W'(WIN_BYTES);
        end else begin
            n_madv = r_miss_advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cmd   <= in_beat.cmd;
            r1_idx   <= in_beat.entry_index;
            r1_slot  <= in_beat.arg_slot;
            r1_mword <= in_beat.mask_word;
            r1_vword <= in_beat.value_word;
            r1_size  <= in_beat.entry_size;
            r1_count <= in_beat.arg_count;
            r1_vb    <= n_vb;
            r1_madv  <= n_madv;
            r1_words <= n_words;
            r1_missw <= n_words[2'(n_madv - LEN_W'(1))];
        end
    end

    // Pattern table write, in order with decodes passing stage 1
    always_ff @(posedge i_clk) begin
        if (en2 && r1_is_wr) begin
            r_pmask[r1_idx] <= r1_mword;
            r_pval[r1_idx]  <= r1_vword;
            r_psize[r1_idx] <= r1_size;
        end
    end

    // Stage 2 logic: masked compare of every entry in use
    always_comb begin
        for (int e = 0; e < TBL_ENTRIES; e++) begin
            n_hit[e] = (EIU_W'(e) < r_entries_in_use)
                    && (r_psize[e] != '0)
                    && (r_psize[e] <= LEN_W'(WIN_BYTES))
                    && (r_psize[e] <= r1_vb)
                    && ((r1_words[2'(r_psize[e] - LEN_W'(1))] & r_pmask[e]) == r_pval[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_cmd   <= r1_cmd;
            r2_hit   <= n_hit;
            r2_idx   <= r1_idx;
            r2_slot  <= r1_slot;
            r2_mword <= r1_mword;
            r2_size  <= r1_size;
            r2_count <= r1_count;
            r2_madv  <= r1_madv;
            r2_words <= r1_words;
            r2_missw <= r1_missw;
        end
    end

    // Stage 3 logic: lowest hit within each group
    always_comb begin
        for (int g = 0; g < GRP_COUNT; g++) begin
            n_gany[g] = |r2_hit[g*GRP_SIZE +: GRP_SIZE];
            n_gloc[g] = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--) begin
                if (r2_hit[g*GRP_SIZE + j]) n_gloc[g] = LOC_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_cmd   <= r2_cmd;
            r3_gany  <= n_gany;
            r3_gloc  <= n_gloc;
            r3_idx   <= r2_idx;
            r3_slot  <= r2_slot;
            r3_mword <= r2_mword;
            r3_size  <= r2_size;
            r3_count <= r2_count;
            r3_madv  <= r2_madv;
            r3_words <= r2_words;
            r3_missw <= r2_missw;
        end
    end

    // Stage 4 logic: lowest group with a hit
    always_comb begin
        n_found = |r3_gany;
        n_hidx  = '0;
        for (int g = GRP_COUNT - 1; g >= 0; g--) begin
            if (r3_gany[g]) n_hidx = {(IDX_W-LOC_W)'(g), r3_gloc[g]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_cmd   <= r3_cmd;
            r4_found <= n_found;
            r4_hidx  <= n_hidx;
            r4_widx  <= r3_idx;
            r4_slot  <= r3_slot;
            r4_mword <= r3_mword;
            r4_size  <= r3_size;
            r4_count <= r3_count;
            r4_madv  <= r3_madv;
            r4_words <= r3_words;
            r4_missw <= r3_missw;
        end
    end

    // Row memory: lane writes from write beats, registered read for decodes
    always_ff @(posedge i_clk) begin
        if (en5 && r4_valid) begin
            case (r4_cmd)
                CMD_WR_ENTRY: begin
                    r_mem[r4_widx].size  <= r4_size;
                    r_mem[r4_widx].count <= r4_count;
                end
                CMD_WR_AMASK: r_mem[r4_widx].amask[r4_slot] <= r4_mword;
                default: ;
            endcase
        end
        if (en5) begin
            r5_row <= r_mem[r4_hidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_found <= r4_found;
            r5_idx   <= r4_hidx;
            r5_madv  <= r4_madv;
            r5_words <= r4_words;
            r5_missw <= r4_missw;
        end
    end

    // Stage 6 logic: pick word, saturate count, mask arguments, count zeros
    always_comb begin
        if (r5_found) begin
            n_word = r5_words[2'(r5_row.size - LEN_W'(1))];
            n_adv  = r5_row.size;
            n_cnt  = (r5_row.count > LEN_W'(MAX_ARGS)) ? LEN_W'(MAX_ARGS) : r5_row.count;
        end else begin
            n_word = r5_missw;
            n_adv  = r5_madv;
            n_cnt  = '0;
        end
        for (int k = 0; k < MAX_ARGS; k++) begin
            // absent argument or zero mask gives a zero masked word;
            // absent slots may hold unwritten masks, so their shift is forced to 0
            n_masked[k] = (LEN_W'(k) < n_cnt) ? (n_word & r5_row.amask[k]) : '0;
            n_ctz[k]    = (LEN_W'(k) < n_cnt) ? ctz32(r5_row.amask[k]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_found  <= r5_found;
            r6_idx    <= r5_found ? r5_idx : '0;
            r6_word   <= n_word;
            r6_adv    <= n_adv;
            r6_cnt    <= n_cnt;
            r6_masked <= n_masked;
            r6_ctz    <= n_ctz;
        end
    end

    // Output register: align each argument down to bit 0
    always_ff @(posedge i_clk) begin
        if (en7) begin
            r_out.matched         <= r6_found;
            r_out.matched_entry   <= r6_idx;
            r_out.instr_word      <= r6_word;
            r_out.advance         <= r6_adv;
            r_out.found_arg_count <= r6_cnt;
            r_out.arg_0           <= r6_masked[0] >> r6_ctz[0];
            r_out.arg_1           <= r6_masked[1] >> r6_ctz[1];
            r_out.arg_2           <= r6_masked[2] >> r6_ctz[2];
            r_out.arg_3           <= r6_masked[3] >> r6_ctz[3];
        end
    end

endmodule
